>>> sv/blf_pkg.sv
// Package: shared types, codes and defaults for the zFilter link forwarder.
package blf_pkg;

    localparam int ID_WORDS_DEF  = 4;
    localparam int MAX_LINKS_DEF = 16;
    localparam int WORD_W        = 64;
    localparam int MAC_W         = 48;
    localparam int CFG_IDX_W     = 3;

    localparam logic [1:0] FUNC_LOAD_ID   = 2'd0;
    localparam logic [1:0] FUNC_LOAD_INFO = 2'd1;
    localparam logic [1:0] FUNC_PACKET    = 2'd2;

    localparam logic [1:0] KIND_FORWARD = 2'd0;
    localparam logic [1:0] KIND_LOCAL   = 2'd1;
    localparam logic [1:0] KIND_DROP    = 2'd2;
    localparam logic [1:0] KIND_REVERSE = 2'd3;

    localparam logic [3:0] CLS_LOCAL_LAST = 4'd4;
    localparam logic [3:0] CLS_SUBINFO    = 4'd2;
    localparam logic [3:0] CLS_NET_DATA   = 4'd5;
    localparam logic [3:0] CLS_NET_PROBE  = 4'd6;
    localparam logic [3:0] CLS_NET_REPLY  = 4'd7;
    localparam logic [3:0] CLS_NET_LAST   = 4'd8;

    localparam logic [3:0] PORT_SUBINFO = 4'd3;
    localparam logic [3:0] PORT_PROBE   = 4'd2;
    localparam logic [3:0] PORT_REPLY   = 4'd4;
    localparam logic [3:0] PORT_DATA    = 4'd0;

    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ID0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ID1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ID2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ID3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINKS_USED = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROC,
        ST_LATCH,
        ST_SCAN,
        ST_TAIL
    } fsm_state_t;

    typedef struct packed {
        logic       id_we;
        logic       info_we;
        logic [3:0] slot;
        logic [1:0] wr_word;
        logic       upd;
        logic       clr;
        logic [1:0] w;
    } cell_ctrl_t;

endpackage

>>> sv/blf_if.sv
// Interfaces: packet/load input channel and result output channel.
interface blf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [3:0]  link_slot;
    logic [1:0]  word_number;
    logic [63:0] id_word;
    logic [63:0] carried_reverse_word;
    logic [3:0]  link_port;
    logic [47:0] first_mac;
    logic [47:0] second_mac;
    logic [3:0]  packet_class;
    logic        last_word;

    modport source (output valid, func, link_slot, word_number, id_word, carried_reverse_word,
                    link_port, first_mac, second_mac, packet_class, last_word, input ready);
    modport sink (input valid, func, link_slot, word_number, id_word, carried_reverse_word,
                  link_port, first_mac, second_mac, packet_class, last_word, output ready);
endinterface

interface blf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [3:0]  matched_link;
    logic [3:0]  destination_port;
    logic [63:0] reverse_word;
    logic [1:0]  reverse_word_number;
    logic        final_result;

    modport source (output valid, result_kind, matched_link, destination_port, reverse_word,
                    reverse_word_number, final_result, input ready);
    modport sink (input valid, result_kind, matched_link, destination_port, reverse_word,
                  reverse_word_number, final_result, output ready);
endinterface

>>> sv/blf_cell.sv
// Link cell: one table entry, its match bit and one step of the reverse-ID chain.
module blf_cell import blf_pkg::*;
#(
    parameter int ID_WORDS   = ID_WORDS_DEF,
    parameter int LINK_INDEX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctrl_t        ctrl,
    input  logic [WORD_W-1:0] wr_data,
    input  logic [3:0]        wr_port,
    input  logic [MAC_W-1:0]  wr_src,
    input  logic [MAC_W-1:0]  wr_dst,
    input  logic [WORD_W-1:0] idw,
    input  logic [MAC_W-1:0]  m1,
    input  logic [MAC_W-1:0]  m2,
    input  logic              active,
    input  logic [WORD_W-1:0] rev_in,
    output logic [WORD_W-1:0] rev_out,
    output logic              match,
    output logic [3:0]        port
);
    localparam int WIDX = (ID_WORDS > 1) ? $clog2(ID_WORDS) : 1;

    logic [WORD_W-1:0] id_reg [ID_WORDS];
    logic [3:0]        port_reg;
    logic [MAC_W-1:0]  src_reg;
    logic [MAC_W-1:0]  dst_reg;
    logic              match_reg;
    logic              slot_hit;
    logic              wr_ok;
    logic              rd_ok;
    logic [WORD_W-1:0] rd;

    assign slot_hit = (32'(ctrl.slot) == LINK_INDEX);
    assign wr_ok    = (32'(ctrl.wr_word) < ID_WORDS);
    assign rd_ok    = (32'(ctrl.w) < ID_WORDS);
    assign rd       = id_reg[WIDX'(ctrl.w)];

    always_ff @(posedge clk)
    begin
        if (ctrl.id_we && slot_hit && wr_ok)
        begin
            id_reg[WIDX'(ctrl.wr_word)] <= wr_data;
        end
        if (ctrl.info_we && slot_hit)
        begin
            port_reg <= wr_port;
            src_reg  <= wr_src;
            dst_reg  <= wr_dst;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b1;
        end
        else if (ctrl.clr)
        begin
            match_reg <= 1'b1;
        end
        else if (ctrl.upd && rd_ok && active && ((idw & rd) != rd))
        begin
            match_reg <= 1'b0;
        end
    end

    assign rev_out = rev_in | ((active && rd_ok && src_reg == m1 && dst_reg == m2) ?
                               rd : '0);
    assign match   = match_reg;
    assign port    = port_reg;

endmodule

>>> sv/bloom_filter_link_forwarder.sv
// Top level: zFilter forwarding decision over a chain of link cells.
//
//  channel   dir   handshake     contents
//  in_ch     in    valid/ready   func, slot, word, id/reverse words, port, MACs, class, last
//  out_ch    out   valid/ready   kind, link, port, reverse word and number, final flag
//  cfg       in    cfg_we        cfg_index, cfg_data (local ID words, links in use)
//
// Loads are written when accepted. A packet word is captured, then given its cell update
// and reverse-ID result (a probe waits for the output); the last word adds a latch step,
// one scan step per matching link (an empty scan when none match) and, for a local packet
// or no match, a local/drop tail step. Results leave one per cycle while out_ch is ready.
// Reset clears control and config registers and sets match bits; link table is undefined until loaded.
// A stalled output holds the sequencer in place.
module bloom_filter_link_forwarder import blf_pkg::*;
#(
    parameter int ID_WORDS  = ID_WORDS_DEF,
    parameter int MAX_LINKS = MAX_LINKS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    blf_in_if.sink               in_ch,
    blf_out_if.source            out_ch
);
    fsm_state_t state_reg, state_next;

    logic [WORD_W-1:0] local_id_reg [4];
    logic [4:0]        used_reg;

    logic [1:0]        w_reg;
    logic [WORD_W-1:0] idw_reg;
    logic [WORD_W-1:0] car_reg;
    logic [MAC_W-1:0]  m1_reg;
    logic [MAC_W-1:0]  m2_reg;
    logic [3:0]        cls_reg;
    logic              last_reg;

    logic all_ones_reg, all_ones_next;
    logic local_reg, local_next;
    logic [MAX_LINKS-1:0] pend_reg, pend_next;
    logic tail_reg, tail_next;
    logic tail_local_reg, tail_local_next;
    logic sub_local_reg, sub_local_next;

    logic        ov_reg, ov_next;
    logic [1:0]  okind_reg, okind_next;
    logic [3:0]  olink_reg, olink_next;
    logic [3:0]  oport_reg, oport_next;
    logic [63:0] orev_reg, orev_next;
    logic [1:0]  orevn_reg, orevn_next;
    logic        ofin_reg, ofin_next;

    cell_ctrl_t           ctrl;
    logic [WORD_W-1:0]    rev_c [MAX_LINKS+1];
    logic [MAX_LINKS-1:0] match;
    logic [3:0]           lport [MAX_LINKS];
    logic [MAX_LINKS-1:0] used_mask;
    logic [MAX_LINKS-1:0] eff;
    logic [MAX_LINKS-1:0] pend_rest;
    logic [3:0]           lp;
    logic                 in_acc;
    logic                 can_load;
    logic                 probe;
    logic                 net;
    logic                 fwd_ok;
    logic                 w_ok;
    logic                 found;
    logic [3:0]           pick_idx;
    logic [3:0]           pick_port;
    logic [31:0]          used_sat;

    assign used_sat = (32'(used_reg) > MAX_LINKS) ? 32'(MAX_LINKS) : 32'(used_reg);

    always_comb
    begin
        for (int j = 0; j < MAX_LINKS; j++)
        begin
            used_mask[j] = (j < used_sat);
        end
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign can_load    = !ov_reg || out_ch.ready;
    assign probe       = (cls_reg == CLS_NET_PROBE) || (cls_reg == CLS_NET_REPLY);
    assign net         = (cls_reg >= CLS_NET_DATA) && (cls_reg <= CLS_NET_LAST);
    assign fwd_ok      = (cls_reg <= CLS_LOCAL_LAST) || (net && !all_ones_reg);
    assign eff         = match & used_mask & {MAX_LINKS{fwd_ok}};
    assign w_ok        = (32'(w_reg) < ID_WORDS);
    assign lp          = (cls_reg == CLS_NET_PROBE) ? PORT_PROBE :
                         (cls_reg == CLS_NET_DATA) ? PORT_DATA : PORT_REPLY;

    always_comb
    begin
        found     = 1'b0;
        pick_idx  = '0;
        pick_port = '0;
        pend_rest = pend_reg;
        for (int j = 0; j < MAX_LINKS; j++)
        begin
            if (!found && pend_reg[j])
            begin
                found        = 1'b1;
                pick_idx     = 4'(j);
                pick_port    = lport[j];
                pend_rest[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                local_id_reg[k] <= '0;
            end
            used_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOCAL_ID0:  local_id_reg[0] <= cfg_data;
                REG_LOCAL_ID1:  local_id_reg[1] <= cfg_data;
                REG_LOCAL_ID2:  local_id_reg[2] <= cfg_data;
                REG_LOCAL_ID3:  local_id_reg[3] <= cfg_data;
                REG_LINKS_USED: used_reg <= cfg_data[4:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            w_reg    <= in_ch.word_number;
            idw_reg  <= in_ch.id_word;
            car_reg  <= in_ch.carried_reverse_word;
            m1_reg   <= in_ch.first_mac;
            m2_reg   <= in_ch.second_mac;
            cls_reg  <= in_ch.packet_class;
            last_reg <= in_ch.last_word;
        end
        okind_reg <= okind_next;
        olink_reg <= olink_next;
        oport_reg <= oport_next;
        orev_reg  <= orev_next;
        orevn_reg <= orevn_next;
        ofin_reg  <= ofin_next;
        pend_reg  <= pend_next;
        tail_reg  <= tail_next;
        tail_local_reg <= tail_local_next;
        sub_local_reg  <= sub_local_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ov_reg       <= 1'b0;
            all_ones_reg <= 1'b1;
            local_reg    <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            ov_reg       <= ov_next;
            all_ones_reg <= all_ones_next;
            local_reg    <= local_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ov_next         = ov_reg && !out_ch.ready;
        okind_next      = okind_reg;
        olink_next      = olink_reg;
        oport_next      = oport_reg;
        orev_next       = orev_reg;
        orevn_next      = orevn_reg;
        ofin_next       = ofin_reg;
        all_ones_next   = all_ones_reg;
        local_next      = local_reg;
        pend_next       = pend_reg;
        tail_next       = tail_reg;
        tail_local_next = tail_local_reg;
        sub_local_next  = sub_local_reg;

        ctrl.id_we   = in_acc && (in_ch.func == FUNC_LOAD_ID);
        ctrl.info_we = in_acc && (in_ch.func == FUNC_LOAD_INFO);
        ctrl.slot    = in_ch.link_slot;
        ctrl.wr_word = in_ch.word_number;
        ctrl.upd     = 1'b0;
        ctrl.clr     = 1'b0;
        ctrl.w       = w_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_ch.func == FUNC_PACKET)
                begin
                    state_next = ST_PROC;
                end
            end
            ST_PROC:
            begin
                if (!probe || can_load)
                begin
                    ctrl.upd = 1'b1;
                    if (w_ok)
                    begin
                        if (idw_reg != '1)
                        begin
                            all_ones_next = 1'b0;
                        end
                        if ((idw_reg & local_id_reg[w_reg]) != local_id_reg[w_reg])
                        begin
                            local_next = 1'b0;
                        end
                    end
                    if (probe)
                    begin
                        ov_next    = 1'b1;
                        okind_next = KIND_REVERSE;
                        olink_next = '0;
                        oport_next = '0;
                        orev_next  = rev_c[MAX_LINKS];
                        orevn_next = w_reg;
                        ofin_next  = !last_reg;
                    end
                    state_next = last_reg ? ST_LATCH : ST_IDLE;
                end
            end
            ST_LATCH:
            begin
                pend_next       = eff;
                tail_local_next = net && local_reg;
                tail_next       = (net && local_reg) || (eff == '0);
                sub_local_next  = (cls_reg == CLS_SUBINFO) && local_reg;
                ctrl.clr        = 1'b1;
                all_ones_next   = 1'b1;
                local_next      = 1'b1;
                state_next      = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!found)
                begin
                    state_next = tail_reg ? ST_TAIL : ST_IDLE;
                end
                else if (can_load)
                begin
                    ov_next    = 1'b1;
                    okind_next = sub_local_reg ? KIND_LOCAL : KIND_FORWARD;
                    olink_next = pick_idx;
                    oport_next = sub_local_reg ? PORT_SUBINFO : pick_port;
                    orev_next  = '0;
                    orevn_next = '0;
                    ofin_next  = (pend_rest == '0) && !tail_reg;
                    pend_next  = pend_rest;
                    if (pend_rest == '0)
                    begin
                        state_next = tail_reg ? ST_TAIL : ST_IDLE;
                    end
                end
            end
            ST_TAIL:
            begin
                if (can_load)
                begin
                    ov_next    = 1'b1;
                    okind_next = tail_local_reg ? KIND_LOCAL : KIND_DROP;
                    olink_next = '0;
                    oport_next = tail_local_reg ? lp : '0;
                    orev_next  = '0;
                    orevn_next = '0;
                    ofin_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rev_c[0] = car_reg;

    for (genvar g = 0; g < MAX_LINKS; g++)
    begin : g_cell
        blf_cell #(
            .ID_WORDS   (ID_WORDS),
            .LINK_INDEX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .wr_data (in_ch.id_word),
            .wr_port (in_ch.link_port),
            .wr_src  (in_ch.first_mac),
            .wr_dst  (in_ch.second_mac),
            .idw     (idw_reg),
            .m1      (m1_reg),
            .m2      (m2_reg),
            .active  (used_mask[g]),
            .rev_in  (rev_c[g]),
            .rev_out (rev_c[g+1]),
            .match   (match[g]),
            .port    (lport[g])
        );
    end

    assign out_ch.valid               = ov_reg;
    assign out_ch.result_kind         = okind_reg;
    assign out_ch.matched_link        = olink_reg;
    assign out_ch.destination_port    = oport_reg;
    assign out_ch.reverse_word        = orev_reg;
    assign out_ch.reverse_word_number = orevn_reg;
    assign out_ch.final_result        = ofin_reg;

endmodule
